/* src/thnq_pkg.sv */
package thnq_pkg;

  localparam int ROW_W    = 64;
  localparam int PERSON_W = 6;
  localparam int NUM_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_NUM_PEOPLE = 1'b0;

  localparam logic [NUM_W-1:0] NUM_PEOPLE_RST = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELF_RD,
    S_SELF,
    S_SCAN,
    S_DONE
  } thnq_state_t;

  typedef struct packed {
    logic wr_en;
    logic q_start;
    logic rd_self;
    logic rd_scan;
    logic ld_direct;
    logic acc_en;
    logic ld_out;
  } thnq_cmd_t;

  typedef struct packed {
    logic oob;
    logic last;
  } thnq_stat_t;

endpackage

/* src/thnq_dp.sv */
module thnq_dp
  import thnq_pkg::*;
#(
  parameter int MAX_PEOPLE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  thnq_cmd_t           cmd,
  output thnq_stat_t          stat,
  input  logic [NUM_W-1:0]    num_people,
  input  logic [PERSON_W-1:0] in_person,
  input  logic [ROW_W-1:0]    in_friend_row,
  output logic [ROW_W-1:0]    out_candidate_row
);

  localparam int AW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_PEOPLE);

  logic [ROW_W-1:0]    mem [MAX_PEOPLE];
  logic [MAX_PEOPLE-1:0] valid_r;
  logic [ROW_W-1:0]    row_q_r;
  logic                vq_r;

  logic [NUM_W-1:0]    n_eff;
  logic [ROW_W-1:0]    mask_nxt;
  logic                in_store;
  logic [AW-1:0]       raddr;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_data;
  logic [ROW_W-1:0]    final_row;

  logic [PERSON_W-1:0] person_r;
  logic [ROW_W-1:0]    mask_r;
  logic [NUM_W-1:0]    n_r;
  logic                oob_r;
  logic [ROW_W-1:0]    direct_r;
  logic [ROW_W-1:0]    acc_r;
  logic [AW-1:0]       scan_idx_r;
  logic [AW-1:0]       pend_r;
  logic [ROW_W-1:0]    out_row_r;

  always_comb begin
    n_eff    = (num_people > MAX_N) ? MAX_N : num_people;
    mask_nxt = (n_eff >= NUM_W'(ROW_W)) ? {ROW_W{1'b1}}
                                        : ((ROW_W'(1) << n_eff) - ROW_W'(1));
    in_store = ({1'b0, in_person} < MAX_N);
    rd_en    = cmd.rd_self | cmd.rd_scan;
    raddr    = cmd.rd_self ? person_r[AW-1:0] : scan_idx_r;
    rd_data  = vq_r ? row_q_r : '0;
    stat.oob  = ({1'b0, in_person} >= n_eff);
    stat.last = (NUM_W'(pend_r) == (n_r - NUM_W'(1)));
    final_row = acc_r & ~direct_r & ~(ROW_W'(1) << person_r) & mask_r;
  end

  // row storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_store) begin
      mem[in_person[AW-1:0]] <= in_friend_row;
    end
    if (rd_en) begin
      row_q_r <= mem[raddr];
    end
  end

  // rows never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vq_r    <= 1'b0;
    end else begin
      if (cmd.wr_en && in_store) begin
        valid_r[in_person[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        vq_r <= valid_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      person_r   <= in_person;
      mask_r     <= mask_nxt;
      n_r        <= n_eff;
      oob_r      <= stat.oob;
      acc_r      <= '0;
      scan_idx_r <= '0;
    end else begin
      if (cmd.rd_scan) begin
        scan_idx_r <= scan_idx_r + AW'(1);
        pend_r     <= scan_idx_r;
      end
      if (cmd.ld_direct) begin
        direct_r <= rd_data & mask_r;
      end
      if (cmd.acc_en && direct_r[pend_r]) begin
        acc_r <= acc_r | (rd_data & mask_r);
      end
    end
    if (cmd.ld_out) begin
      out_row_r <= oob_r ? '0 : final_row;
    end
  end

  assign out_candidate_row = out_row_r;

endmodule

/* src/thnq_ctrl.sv */
module thnq_ctrl
  import thnq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_kind,
  input  thnq_stat_t stat,
  output thnq_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  thnq_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            state_nxt   = stat.oob ? S_DONE : S_SELF_RD;
          end
        end
      end
      S_SELF_RD: begin
        cmd.rd_self = 1'b1;
        state_nxt   = S_SELF;
      end
      S_SELF: begin
        cmd.ld_direct = 1'b1;
        cmd.rd_scan   = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        // fold pending row, prefetch the next one
        cmd.acc_en = 1'b1;
        if (stat.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      S_DONE: begin
        cmd.ld_out    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/two_hop_neighbor_query_unit.sv */
// Two-hop neighbor query over a friend adjacency matrix.
// Input: start with in_kind, in_person, in_friend_row; an item transfers at a
// clock edge where start is high and busy is low.
// A write (in_kind 0) stores in_friend_row as the person's row and gives no
// result; a person at or above MAX_PEOPLE is dropped.
// A query (in_kind 1) returns out_candidate_row with a one-cycle out_valid strobe.
// With n the active people count (num_people capped at MAX_PEOPLE), a query
// does one read of the queried row, then reads one friend row per cycle through
// the single read port of the row memory.
// A query of a person at or above n skips the row reads and returns zero.
// busy falls in the cycle the strobe is shown, so the next item may transfer then.
// The receiver cannot hold results off; each result is shown for one cycle.
// Reset clears all rows (per-row valid flags, no clearing pass) and sets
// num_people to 64. num_people sits at APB address 0; pready is always high.
module two_hop_neighbor_query_unit
  import thnq_pkg::*;
#(
  parameter int MAX_PEOPLE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [PERSON_W-1:0] in_person,
  input  logic [ROW_W-1:0]    in_friend_row,
  output logic                out_valid,
  output logic [ROW_W-1:0]    out_candidate_row,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  thnq_cmd_t        cmd;
  thnq_stat_t       stat;
  logic [NUM_W-1:0] num_people_r;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_NUM_PEOPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_people_r <= NUM_PEOPLE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      num_people_r <= pwdata[NUM_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(num_people_r) : '0;

  thnq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  thnq_dp #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .num_people        (num_people_r),
    .in_person         (in_person),
    .in_friend_row     (in_friend_row),
    .out_candidate_row (out_candidate_row)
  );

endmodule
